// ===== src/bsr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsr_pkg
// Shared types, codes and helpers of the bitmap shape rasterizer.
// ----------------------------------------------------------------------------
package bsr_pkg;

   // command codes
   localparam logic [1:0] REQ_SQUARE   = 2'd0;
   localparam logic [1:0] REQ_LINE     = 2'd1;
   localparam logic [1:0] REQ_TRIANGLE = 2'd2;
   localparam logic [1:0] REQ_CLEAR    = 2'd3;

   // register indexes
   localparam logic CSR_GRID_ROWS = 1'b0;
   localparam logic CSR_GRID_COLS = 1'b1;

   localparam int COORD_W = 10;
   localparam int GRID_W  = 64;

   typedef logic signed [COORD_W-1:0] coord_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic clear_all;
      logic cnt_clr;
      logic cnt_inc;
      logic rd_en;
      logic wr_en;
      logic show_err;
   } ctrl_type;

   // datapath to controller
   typedef struct packed {
      logic shape_ok;
      logic is_clear;
      logic cnt_last_draw;
      logic cnt_last_out;
   } stat_type;

   // columns lo..hi inclusive, clipped to the word
   function automatic logic [GRID_W-1:0] range_mask(coord_type lo, coord_type hi);
      logic [GRID_W-1:0] m;
      coord_type         n;
      m = '0;
      for (int k = 0; k < GRID_W; k++) begin
         n    = coord_type'(k);
         m[k] = (n >= lo) && (n <= hi);
      end
      return m;
   endfunction

endpackage

// ===== src/bsr_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bsr_datapath
// Command registers, range checks, row mask generation and the grid memory.
// ----------------------------------------------------------------------------
module bsr_datapath #(
   parameter int MAX_DIM = 64
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire bsr_pkg::ctrl_type     ctrl,
   output bsr_pkg::stat_type          stat,
   input  wire logic [1:0]            req_type,
   input  wire logic signed [7:0]     req_row_a,
   input  wire logic signed [7:0]     req_col_a,
   input  wire logic signed [7:0]     req_row_b,
   input  wire logic signed [7:0]     req_col_b,
   input  wire logic [6:0]            req_side_length,
   input  wire logic [1:0]            req_direction,
   input  wire logic                  csr_write,
   input  wire logic                  csr_index,
   input  wire logic [6:0]            csr_data,
   output logic [5:0]                 rsp_row_number,
   output logic [63:0]                rsp_row_bits,
   output logic                       rsp_last
);

   localparam int AW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
   localparam logic [6:0] DIM7 = 7'(MAX_DIM);

   typedef bsr_pkg::coord_type coord_type;

   // config registers
   logic [6:0] rows_raw_ff, cols_raw_ff;
   logic [6:0] rows_c, cols_c;

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_raw_ff <= 7'd64;
         cols_raw_ff <= 7'd64;
      end else if (csr_write) begin
         unique case (csr_index)
            bsr_pkg::CSR_GRID_ROWS: rows_raw_ff <= csr_data;
            default:                cols_raw_ff <= csr_data;
         endcase
      end
   end

   // clamp to 1..MAX_DIM
   always_comb begin
      rows_c = (rows_raw_ff == 7'd0) ? 7'd1 : (rows_raw_ff > DIM7) ? DIM7 : rows_raw_ff;
      cols_c = (cols_raw_ff == 7'd0) ? 7'd1 : (cols_raw_ff > DIM7) ? DIM7 : cols_raw_ff;
   end

   // command registers
   logic [1:0] type_ff, dir_ff;
   coord_type  ra_ff, ca_ff, rb_ff, cb_ff, h_ff;

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         type_ff <= req_type;
         dir_ff  <= req_direction;
         ra_ff   <= coord_type'(req_row_a);
         ca_ff   <= coord_type'(req_col_a);
         rb_ff   <= coord_type'(req_row_b);
         cb_ff   <= coord_type'(req_col_b);
         h_ff    <= coord_type'($signed({1'b0, req_side_length})) - coord_type'(1);
      end
   end

   function automatic logic in_grid(coord_type r, coord_type c, logic [6:0] nr,
                                    logic [6:0] nc);
      return (r >= 0) && (r < coord_type'($signed({1'b0, nr})))
          && (c >= 0) && (c < coord_type'($signed({1'b0, nc})));
   endfunction

   function automatic coord_type abs_c(coord_type v);
      return (v < 0) ? -v : v;
   endfunction

   // range checks
   coord_type pr, qc;
   logic      ok;

   always_comb begin
      pr = dir_ff[1] ? ra_ff + h_ff : ra_ff - h_ff;
      qc = dir_ff[0] ? ca_ff + h_ff : ca_ff - h_ff;
      case (type_ff)
         bsr_pkg::REQ_SQUARE:
            ok = in_grid(ra_ff, ca_ff, rows_c, cols_c)
              && in_grid(ra_ff + h_ff, ca_ff + h_ff, rows_c, cols_c);
         bsr_pkg::REQ_LINE:
            ok = in_grid(ra_ff, ca_ff, rows_c, cols_c)
              && in_grid(rb_ff, cb_ff, rows_c, cols_c);
         bsr_pkg::REQ_TRIANGLE:
            ok = in_grid(ra_ff, ca_ff, rows_c, cols_c)
              && in_grid(pr, ca_ff, rows_c, cols_c)
              && in_grid(ra_ff, qc, rows_c, cols_c);
         default: ok = 1'b1;
      endcase
   end

   // row counter
   logic [AW-1:0] cnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (ctrl.cnt_clr) begin
         cnt_ff <= '0;
      end else if (ctrl.cnt_inc) begin
         cnt_ff <= cnt_ff + AW'(1);
      end
   end

   // columns marked in the current row
   coord_type         r, t0, dclen, m, c1, c2, i, cend, lo, hi;
   logic              hit;
   logic [63:0]       row_mask;

   always_comb begin
      r     = coord_type'($signed({1'b0, cnt_ff}));
      t0    = abs_c(r - ra_ff);
      dclen = abs_c(cb_ff - ca_ff);
      m     = (t0 < dclen) ? t0 : dclen;
      c1    = (cb_ff > ca_ff) ? ca_ff + m : ca_ff - m;
      c2    = (r == rb_ff) ? cb_ff : c1;
      i     = dir_ff[1] ? r - ra_ff : ra_ff - r;
      cend  = ca_ff;
      hit   = 1'b0;
      lo    = ca_ff;
      hi    = ca_ff;
      case (type_ff)
         bsr_pkg::REQ_SQUARE: begin
            hit = (r >= ra_ff) && (r <= ra_ff + h_ff);
            hi  = ca_ff + h_ff;
         end
         bsr_pkg::REQ_LINE: begin
            hit = (rb_ff >= ra_ff) ? ((r >= ra_ff) && (r <= rb_ff))
                                   : ((r <= ra_ff) && (r >= rb_ff));
            lo  = (c1 < c2) ? c1 : c2;
            hi  = (c1 < c2) ? c2 : c1;
         end
         bsr_pkg::REQ_TRIANGLE: begin
            if (h_ff >= 0) begin
               hit  = (i >= 0) && (i <= h_ff);
               cend = dir_ff[0] ? ca_ff + (h_ff - i) : ca_ff - (h_ff - i);
            end else begin
               // zero side: corner plus one pixel back along each axis
               hit  = (i == 0) || (i == -1);
               cend = (i == 0) ? (dir_ff[0] ? ca_ff - coord_type'(1)
                                            : ca_ff + coord_type'(1)) : ca_ff;
            end
            lo = (cend < ca_ff) ? cend : ca_ff;
            hi = (cend < ca_ff) ? ca_ff : cend;
         end
         default: hit = 1'b0;
      endcase
      row_mask = hit ? bsr_pkg::range_mask(lo, hi) : '0;
   end

   // grid memory with per-row valid bits
   logic [63:0]  mem_ff [MAX_DIM];
   logic [MAX_DIM-1:0] vld_ff;
   logic [63:0]  rd_data_ff;
   logic         rd_vld_ff;
   logic [63:0]  cur_row;

   assign cur_row = rd_vld_ff ? rd_data_ff : '0;

   always_ff @(posedge clock) begin
      if (ctrl.wr_en) begin
         mem_ff[cnt_ff] <= cur_row | row_mask;
      end
      if (ctrl.rd_en) begin
         rd_data_ff <= mem_ff[cnt_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset || ctrl.clear_all) begin
         vld_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         if (ctrl.wr_en) begin
            vld_ff[cnt_ff] <= 1'b1;
         end
         if (ctrl.rd_en) begin
            rd_vld_ff <= vld_ff[cnt_ff];
         end
      end
   end

   // column mask of the grid in use
   logic [63:0] col_mask;

   always_comb begin
      for (int k = 0; k < 64; k++) begin
         col_mask[k] = (7'(k) < cols_c);
      end
   end

   // status and result word
   assign stat.shape_ok      = ok;
   assign stat.is_clear      = (type_ff == bsr_pkg::REQ_CLEAR);
   assign stat.cnt_last_draw = (cnt_ff == AW'(MAX_DIM - 1));
   assign stat.cnt_last_out  = ({1'b0, 6'(cnt_ff)} == rows_c - 7'd1);

   assign rsp_row_number = ctrl.show_err ? 6'd0 : 6'(cnt_ff);
   assign rsp_row_bits   = ctrl.show_err ? 64'd0 : (cur_row & col_mask);
   assign rsp_last       = ctrl.show_err ? 1'b1 : stat.cnt_last_out;

endmodule
`default_nettype wire

// ===== src/bsr_controller.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bsr_controller
// Sequences range check, row-by-row drawing and row readout.
// ----------------------------------------------------------------------------
module bsr_controller (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic                   rsp_status,
   output bsr_pkg::ctrl_type      ctrl,
   input  wire bsr_pkg::stat_type stat
);

   typedef enum logic [2:0] {
      IDLE, CHECK, DRAW_RD, DRAW_WR, OUT_RD, OUT_SHOW, OUT_ERR
   } state_type;

   state_type state_ff, state_in;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         IDLE:     if (req_valid) state_in = CHECK;
         CHECK: begin
            if (!stat.shape_ok)     state_in = OUT_ERR;
            else if (stat.is_clear) state_in = OUT_RD;
            else                    state_in = DRAW_RD;
         end
         DRAW_RD:  state_in = DRAW_WR;
         DRAW_WR:  state_in = stat.cnt_last_draw ? OUT_RD : DRAW_RD;
         OUT_RD:   state_in = OUT_SHOW;
         OUT_SHOW: if (rsp_ready) state_in = stat.cnt_last_out ? IDLE : OUT_RD;
         OUT_ERR:  if (rsp_ready) state_in = IDLE;
         default:  state_in = IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // datapath commands
   always_comb begin
      ctrl           = '0;
      ctrl.load      = (state_ff == IDLE) && req_valid;
      ctrl.cnt_clr   = (state_ff == CHECK) || ((state_ff == DRAW_WR) && stat.cnt_last_draw);
      ctrl.clear_all = (state_ff == CHECK) && stat.shape_ok && stat.is_clear;
      ctrl.rd_en     = (state_ff == DRAW_RD) || (state_ff == OUT_RD);
      ctrl.wr_en     = (state_ff == DRAW_WR);
      ctrl.cnt_inc   = ((state_ff == DRAW_WR) && !stat.cnt_last_draw)
                    || ((state_ff == OUT_SHOW) && rsp_ready && !stat.cnt_last_out);
      ctrl.show_err  = (state_ff == OUT_ERR);
   end

   assign req_ready  = (state_ff == IDLE);
   assign rsp_valid  = (state_ff == OUT_SHOW) || (state_ff == OUT_ERR);
   assign rsp_status = (state_ff == OUT_ERR);

endmodule
`default_nettype wire

// ===== src/bitmap_shape_rasterizer.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bitmap_shape_rasterizer
// One-bit-per-pixel grid that draws squares, lines and triangles, or clears,
// then returns every row of the grid in use (one error word if out of range).
// ----------------------------------------------------------------------------
// channel  direction  handshake              payload
// req      in         req_valid/req_ready    type, corners, side, direction
// rsp      out        rsp_valid/rsp_ready    status, row number, row bits, last
// csr      in         csr_valid/csr_ready    index, data (7 bits)
//
// A draw visits all MAX_DIM grid rows, each by a memory read (DRAW_RD), then
// a read-modify-write (DRAW_WR), then reads (OUT_RD) and delivers (OUT_SHOW)
// each row in use. A clear skips drawing; per-row valid bits clear the grid.
// Out of range returns one word after the check. Reset is synchronous;
// rsp stalls hold the current row, and req is taken only when idle.
// ----------------------------------------------------------------------------
module bitmap_shape_rasterizer #(
   parameter int MAX_DIM = 64
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic [1:0]        req_type,
   input  wire logic signed [7:0] req_row_a,
   input  wire logic signed [7:0] req_col_a,
   input  wire logic signed [7:0] req_row_b,
   input  wire logic signed [7:0] req_col_b,
   input  wire logic [6:0]        req_side_length,
   input  wire logic [1:0]        req_direction,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic                   rsp_status,
   output logic [5:0]             rsp_row_number,
   output logic [63:0]            rsp_row_bits,
   output logic                   rsp_last,
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic              csr_index,
   input  wire logic [6:0]        csr_data
);

   bsr_pkg::ctrl_type ctrl;
   bsr_pkg::stat_type stat;

   assign csr_ready = 1'b1;

   bsr_controller u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_status (rsp_status),
      .ctrl       (ctrl),
      .stat       (stat)
   );

   bsr_datapath #(.MAX_DIM(MAX_DIM)) u_dp (
      .clock           (clock),
      .reset           (reset),
      .ctrl            (ctrl),
      .stat            (stat),
      .req_type        (req_type),
      .req_row_a       (req_row_a),
      .req_col_a       (req_col_a),
      .req_row_b       (req_row_b),
      .req_col_b       (req_col_b),
      .req_side_length (req_side_length),
      .req_direction   (req_direction),
      .csr_write       (csr_valid & csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .rsp_row_number  (rsp_row_number),
      .rsp_row_bits    (rsp_row_bits),
      .rsp_last        (rsp_last)
   );

endmodule
`default_nettype wire
